@@ src/ffba_pkg.sv @@
// shared types, constants and codes of the first-fit block space allocator
package ffba_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int SIZE_BITS  = 16;
  localparam int BLK_BITS   = $clog2(MAX_BLOCKS);
  localparam int CFG_W      = 16;
  localparam int OUT_BLK_W  = 8;
  localparam int OUT_FREE_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = CFG_W'(4096);

  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic                 action;
    logic [SIZE_BITS-1:0] size;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic                  new_block;
    logic                  reopened;
    logic [OUT_FREE_W-1:0] flushed_free;
    logic [OUT_BLK_W-1:0]  flushed_block;
    logic                  flushed;
    logic [OUT_BLK_W-1:0]  assigned_block;
  } result_t;

endpackage

@@ src/ffba_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ffba_ctrl.sv @@
// allocator control: open block state, free table and first-fit scan
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  input  logic [CFG_W-1:0] block_size,
  output logic             done,
  output result_t          res
);

  state_t state, state_next;

  logic [BLK_BITS-1:0]   open_block, open_block_next;
  logic [SIZE_BITS-1:0]  open_free, open_free_next;
  logic [BLK_BITS-1:0]   highest, highest_next;
  logic [BLK_BITS-1:0]   rd_idx, rd_idx_next;
  logic                  rd_end, rd_end_next;
  logic                  chk_pend, chk_pend_next;
  logic [BLK_BITS-1:0]   chk_idx, chk_idx_next;

  logic                 we;
  logic [SIZE_BITS-1:0] rdata;
  logic [SIZE_BITS-1:0] bsize;
  logic                 too_big, fits, issue, hit, miss, full;

  ffba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_free_table (
    .clk   (clk),
    .we    (we),
    .waddr (open_block),
    .wdata (open_free),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // decode of the current request and scan step
  // every block up to highest other than the open one has been written out,
  // so the scanned entries are all known without per-entry flags
  always_comb begin
    bsize   = SIZE_BITS'(block_size);
    too_big = req.size > bsize;
    fits    = open_free >= req.size;
    issue   = (state == ST_SCAN) && !rd_end;
    hit     = (state == ST_SCAN) && chk_pend &&
              (chk_idx != open_block) && (rdata >= req.size);
    miss    = (state == ST_SCAN) && rd_end && !chk_pend;
    full    = highest == BLK_BITS'(MAX_BLOCKS - 1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && req.action == ACT_PLACE && !too_big && !fits) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    done            = 1'b0;
    we              = 1'b0;
    res             = '0;
    res.status      = STAT_OK;
    res.assigned_block = OUT_BLK_W'(open_block);
    open_block_next = open_block;
    open_free_next  = open_free;
    highest_next    = highest;
    rd_idx_next     = rd_idx;
    rd_end_next     = rd_end;
    chk_pend_next   = 1'b0;
    chk_idx_next    = chk_idx;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.action == ACT_CLOSE) begin
            done                  = 1'b1;
            we                    = 1'b1;
            res.flushed           = 1'b1;
            res.flushed_block     = OUT_BLK_W'(open_block);
            res.flushed_free      = OUT_FREE_W'(open_free);
          end else if (too_big) begin
            done       = 1'b1;
            res.status = STAT_TOO_BIG;
          end else if (fits) begin
            done           = 1'b1;
            open_free_next = open_free - req.size;
          end else begin
            rd_idx_next = '0;
            rd_end_next = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, its entry checked in the next cycle from the registered read data
        if (issue) begin
          rd_idx_next   = rd_idx + BLK_BITS'(1);
          chk_idx_next  = rd_idx;
          chk_pend_next = 1'b1;
          if (rd_idx == highest) begin
            rd_end_next = 1'b1;
          end
        end
        if (hit) begin
          done                   = 1'b1;
          we                     = 1'b1;
          open_block_next        = chk_idx;
          open_free_next         = rdata - req.size;
          res.assigned_block     = OUT_BLK_W'(chk_idx);
          res.flushed            = 1'b1;
          res.flushed_block      = OUT_BLK_W'(open_block);
          res.flushed_free       = OUT_FREE_W'(open_free);
          res.reopened           = 1'b1;
        end else if (miss) begin
          done = 1'b1;
          if (full) begin
            res.status = STAT_FULL;
          end else begin
            we                     = 1'b1;
            highest_next           = highest + BLK_BITS'(1);
            open_block_next        = highest + BLK_BITS'(1);
            open_free_next         = bsize - req.size;
            res.assigned_block     = OUT_BLK_W'(highest + BLK_BITS'(1));
            res.flushed            = 1'b1;
            res.flushed_block      = OUT_BLK_W'(open_block);
            res.flushed_free       = OUT_FREE_W'(open_free);
            res.new_block          = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      open_block <= '0;
      open_free  <= SIZE_BITS'(BLOCK_SIZE_RST);
      highest    <= '0;
      rd_idx     <= '0;
      rd_end     <= 1'b0;
      chk_pend   <= 1'b0;
      chk_idx    <= '0;
    end else begin
      state      <= state_next;
      open_block <= open_block_next;
      open_free  <= open_free_next;
      highest    <= highest_next;
      rd_idx     <= rd_idx_next;
      rd_end     <= rd_end_next;
      chk_pend   <= chk_pend_next;
      chk_idx    <= chk_idx_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_highest_mono: assert property (@(posedge clk) disable iff (rst)
    highest >= $past(highest))
    else $error("highest block number went down");

  a_error_no_flush: assert property (@(posedge clk) disable iff (rst)
    done && (res.status != STAT_OK) |-> !res.flushed)
    else $error("error result flushed a block");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.reopened && res.new_block))
    else $error("reopen and new block in the same result");

  a_open_in_range: assert property (@(posedge clk) disable iff (rst)
    open_block <= highest)
    else $error("open block above highest block");
`endif

endmodule

@@ src/first_fit_block_space_allocator.sv @@
// top level of the first-fit block space allocator
//
// places variable-size records into fixed-size blocks of block_size bytes.
// a request on s_* either places a record (s_tuser = 0) or closes and flushes
// the open block (s_tuser = 1); every request gives exactly one result on m_*.
// a record that fits the open block, an oversized record and a close are each
// captured in the request register, then the open block is updated and the
// result registered. a record that does not fit starts a first-fit scan of the
// free table, which is a ram with one read port read one entry per cycle from
// block 0 up to the highest block number used so far. one request is held
// while a finished result waits on m_*, so a new request is taken once the
// previous one has produced its result. block_size is written through cfg_*
// and must only change while no request is in flight; the open block keeps its
// free space across a change. the free table needs no clearing after reset: an
// entry's value is used only after its block was flushed.
module first_fit_block_space_allocator
  import ffba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] record_size
  input  logic                  s_tuser,   // [0] action
  // result channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] assigned_block, [8] flushed,
                                           // [16:9] flushed_block,
                                           // [32:17] flushed_free, [33] reopened,
                                           // [34] new_block, [36:35] status,
                                           // [39:37] zero
  // block_size register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic             req_valid;
  req_t             req;
  logic [CFG_W-1:0] block_size;
  logic             start;
  logic             done;
  result_t          res;
  result_t          out_res;

  // request holding register, freed when its result is produced
  assign s_tready = !req_valid;

  // the result register is empty or draining, so a result can be loaded
  assign start = req_valid && (!m_tvalid || m_tready);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      req_valid <= 1'b1;
    end else if (done) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.action <= s_tuser;
      req.size   <= SIZE_BITS'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      block_size <= cfg_data;
    end
  end

  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .block_size (block_size),
    .done       (done),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_DATA_W'(out_res);

endmodule

@@ tb/first_fit_block_space_allocator_test.sv @@
// self-checking testbench for the first-fit block space allocator
module first_fit_block_space_allocator_test;
  import ffba_pkg::*;

  localparam int RES_W        = $bits(result_t);
  localparam int SEGMENTS     = 8;
  localparam int SEG_REQUESTS = 120;
  localparam int HOLD_CYCLES  = 400;
  // drain time covers the worst scan, plus margin for a stalled receiver
  localparam int DRAIN_CYCLES = MAX_BLOCKS + 40;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_N        = 18;

  // one row of the directed table; the expected fields count only when typed is set
  typedef struct packed {
    logic                  act;
    logic [SIZE_BITS-1:0]  size;
    logic                  typed;
    logic [OUT_BLK_W-1:0]  blk;
    logic                  fl;
    logic [OUT_BLK_W-1:0]  fblk;
    logic [OUT_FREE_W-1:0] ffree;
    logic                  reop;
    logic                  fresh;
    status_t               st;
  } dir_row_t;

  // block_size stays at its reset value of 4096 for the whole table
  //   act        size     typed  blk   fl    fblk  ffree      reop  fresh status
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ACT_PLACE, 16'd0,    1'b1, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'hFFFF, 1'b1, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_TOO_BIG},
    '{ACT_PLACE, 16'd4097, 1'b1, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_TOO_BIG},
    '{ACT_CLOSE, 16'hFFFF, 1'b1, 8'd0, 1'b1, 8'd0, 16'd4096, 1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd4096, 1'b1, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd1,    1'b1, 8'd1, 1'b1, 8'd0, 16'd0,    1'b0, 1'b1, STAT_OK},
    '{ACT_PLACE, 16'd4095, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd2000, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_CLOSE, 16'd0,    1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd3000, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd2000, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd96,   1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd1000, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd96,   1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'h5555, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'hAAAA, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_PLACE, 16'd1,    1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK},
    '{ACT_CLOSE, 16'h0F0F, 1'b0, 8'd0, 1'b0, 8'd0, 16'd0,    1'b0, 1'b0, STAT_OK}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  // own copy of the allocator state
  int                    blk_size;
  logic [SIZE_BITS-1:0]  free_tab [MAX_BLOCKS];
  bit                    tab_valid [MAX_BLOCKS];
  int                    cur_blk;
  int                    cur_free;
  int                    top_blk;

  // results still owed by the block, oldest first
  result_t               awaited_allocs [$];

  // idle percentages and the long receiver hold-off request
  int                    send_gap;
  int                    recv_gap;
  bit                    hold_req = 1'b0;

  int                    mismatch_cnt = 0;
  int                    result_cnt = 0;
  int                    request_cnt = 0;
  int                    size_writes = 0;
  int                    status_seen [3] = '{0, 0, 0};
  int                    flush_cnt = 0;
  int                    reopen_cnt = 0;
  int                    fresh_cnt = 0;

  first_fit_block_space_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard limit, far above the slowest legal run
  initial begin
    #6000000;
    $display("first_fit_block_space_allocator verification failed");
    $finish;
  end

  // state after reset: block 0 open and empty, only entry 0 known
  function automatic void reset_block_state();
    blk_size = 4096;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_tab[i]  = '0;
      tab_valid[i] = 1'b0;
    end
    free_tab[0]  = SIZE_BITS'(blk_size);
    tab_valid[0] = 1'b1;
    cur_blk  = 0;
    cur_free = blk_size;
    top_blk  = 0;
  endfunction

  // what one request does to the blocks, and the result it reports
  function automatic result_t predict_allocation(input logic act,
                                                 input logic [SIZE_BITS-1:0] sz);
    result_t r;
    int      found;
    int      avail;
    int      old_blk;
    int      old_free;
    r = '0;
    r.status = STAT_OK;
    r.assigned_block = OUT_BLK_W'(cur_blk);
    // close: write the open block out, it stays open
    if (act == ACT_CLOSE) begin
      free_tab[cur_blk]  = SIZE_BITS'(cur_free);
      tab_valid[cur_blk] = 1'b1;
      r.flushed       = 1'b1;
      r.flushed_block = OUT_BLK_W'(cur_blk);
      r.flushed_free  = OUT_FREE_W'(cur_free);
      return r;
    end
    // oversized record, judged against the current block_size
    if (int'(sz) > blk_size) begin
      r.status = STAT_TOO_BIG;
      return r;
    end
    if (cur_free >= int'(sz)) begin
      cur_free = cur_free - int'(sz);
      return r;
    end
    // first fit in block order, open block counted with its live free space
    found = -1;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i == cur_blk)
        avail = cur_free;
      else if (tab_valid[i])
        avail = int'(free_tab[i]);
      else
        avail = -1;
      if (avail >= int'(sz)) begin
        found = i;
        break;
      end
    end
    // no room anywhere and no block number left
    if (found < 0 && top_blk + 1 >= MAX_BLOCKS) begin
      r.status = STAT_FULL;
      return r;
    end
    old_blk  = cur_blk;
    old_free = cur_free;
    free_tab[old_blk]  = SIZE_BITS'(old_free);
    tab_valid[old_blk] = 1'b1;
    if (found >= 0) begin
      cur_blk  = found;
      cur_free = int'(free_tab[found]) - int'(sz);
      r.reopened = 1'b1;
    end else begin
      top_blk  = top_blk + 1;
      cur_blk  = top_blk;
      cur_free = blk_size - int'(sz);
      r.new_block = 1'b1;
    end
    r.assigned_block = OUT_BLK_W'(cur_blk);
    r.flushed        = 1'b1;
    r.flushed_block  = OUT_BLK_W'(old_blk);
    r.flushed_free   = OUT_FREE_W'(old_free);
    return r;
  endfunction

  // record size mix: edges around block_size and the open block's room,
  // oversized records, and mostly small records so blocks fill slowly
  function automatic logic [SIZE_BITS-1:0] pick_record_size();
    int r;
    int hi;
    r = $urandom_range(99);
    if (r < 5)
      return '0;
    if (r < 10)
      return SIZE_BITS'(blk_size);
    if (r < 16)
      return (blk_size >= 65535) ? 16'hFFFF : SIZE_BITS'($urandom_range(65535, blk_size + 1));
    if (r < 23)
      return SIZE_BITS'(cur_free);
    if (r < 28)
      return (cur_free >= 65535) ? 16'hFFFF : SIZE_BITS'(cur_free + 1);
    hi = blk_size / 16;
    if (hi < 1)
      hi = 1;
    return SIZE_BITS'($urandom_range(hi, 1));
  endfunction

  // offer one request, with random idle cycles first; valid stays high
  // afterwards so back-to-back requests never drop it
  task automatic offer_request(input logic act, input logic [SIZE_BITS-1:0] sz,
                               input bit use_given, input result_t given);
    result_t predicted;
    while ($urandom_range(99) < send_gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= sz;
    do @(posedge clk); while (!s_tready);
    predicted = predict_allocation(act, sz);
    awaited_allocs.insert(awaited_allocs.size(), use_given ? given : predicted);
    request_cnt++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (awaited_allocs.size() != 0)
      @(posedge clk);
  endtask

  // block_size write, only while nothing is in flight
  task automatic write_block_size(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blk_size = value;
    size_writes++;
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch at result %0d: %s", result_cnt, what);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // result receiver: random idling, or a long hold-off counted here
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_gap);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_t want;
      result_t got;
      result_cnt++;
      got = result_t'(m_tdata[RES_W-1:0]);
      if (awaited_allocs.size() == 0) begin
        flag_mismatch($sformatf("result %h with no request outstanding", m_tdata));
      end else begin
        want = awaited_allocs.pop_front();
        check_field("assigned_block", 32'(want.assigned_block), 32'(got.assigned_block));
        check_field("flushed", 32'(want.flushed), 32'(got.flushed));
        check_field("flushed_block", 32'(want.flushed_block), 32'(got.flushed_block));
        check_field("flushed_free", 32'(want.flushed_free), 32'(got.flushed_free));
        check_field("reopened", 32'(want.reopened), 32'(got.reopened));
        check_field("new_block", 32'(want.new_block), 32'(got.new_block));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("padding", 0, 32'(m_tdata[OUT_DATA_W-1:RES_W]));
      end
      if (got.status <= STAT_FULL)
        status_seen[got.status]++;
      if (got.flushed)
        flush_cnt++;
      if (got.reopened)
        reopen_cnt++;
      if (got.new_block)
        fresh_cnt++;
    end
  end

  // stimulus: directed table, random segments over several block sizes,
  // then filling every block number until the table is full
  initial begin
    result_t given;
    int      seg_size;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = ACT_PLACE;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    send_gap  = 33;
    recv_gap  = 84;
    reset_block_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset block_size
    for (int n = 0; n < DIR_N; n++) begin
      given.assigned_block = DIR_ROWS[n].blk;
      given.flushed        = DIR_ROWS[n].fl;
      given.flushed_block  = DIR_ROWS[n].fblk;
      given.flushed_free   = DIR_ROWS[n].ffree;
      given.reopened       = DIR_ROWS[n].reop;
      given.new_block      = DIR_ROWS[n].fresh;
      given.status         = DIR_ROWS[n].st;
      offer_request(DIR_ROWS[n].act, DIR_ROWS[n].size, DIR_ROWS[n].typed, given);
    end

    // random segments; each starts from an idle block with a new block_size
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_all_results();
      case (seg)
        0: seg_size = 65535;
        1: seg_size = 1;
        2: seg_size = $urandom_range(65535, 1);
        3: seg_size = 4096;
        4: seg_size = 300;
        5: seg_size = $urandom_range(1000, 2);
        6: seg_size = $urandom_range(65535, 1000);
        default: seg_size = 16;
      endcase
      write_block_size(seg_size);
      // sender-light then receiver-light idling, then none at all
      if (seg < 3) begin
        send_gap = 33;
        recv_gap = 84;
      end else if (seg < 6) begin
        send_gap = 84;
        recv_gap = 33;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      // receiver holds off while requests keep coming, so the input backs up
      if (seg == 6)
        hold_req = 1'b1;
      for (int k = 0; k < SEG_REQUESTS; k++) begin
        if ($urandom_range(9) == 0)
          offer_request(ACT_CLOSE, SIZE_BITS'($urandom), 1'b0, '0);
        else
          offer_request(ACT_PLACE, pick_record_size(), 1'b0, '0);
      end
    end

    // full-size records only fit fresh blocks: use up every block number
    wait_all_results();
    write_block_size(65535);
    while (top_blk < MAX_BLOCKS - 1)
      offer_request(ACT_PLACE, 16'hFFFF, 1'b0, '0);
    offer_request(ACT_PLACE, 16'hFFFF, 1'b0, '0);
    offer_request(ACT_PLACE, 16'd0, 1'b0, '0);
    offer_request(ACT_CLOSE, 16'd0, 1'b0, '0);
    offer_request(ACT_PLACE, 16'd1, 1'b0, '0);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests over %0d block_size settings: %0d ok, %0d oversized, %0d table full",
             request_cnt, size_writes, status_seen[STAT_OK], status_seen[STAT_TOO_BIG],
             status_seen[STAT_FULL]);
    $display("%0d blocks written out, %0d reopened by first fit, %0d fresh, %0d mismatches",
             flush_cnt, reopen_cnt, fresh_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && awaited_allocs.size() == 0) begin
      $display("first_fit_block_space_allocator verification clean");
    end else begin
      $display("first_fit_block_space_allocator verification failed");
    end
    $finish;
  end

endmodule
